[rtl/sgr_pkg.sv]
// Shared constants and types for the sort and group rank block.
// No dependencies.
package sgr_pkg;
  localparam int unsigned MaxRecords = 1024;
  localparam int unsigned MaxGroups  = 128;
  localparam int unsigned IdW    = 44;
  localparam int unsigned ScoreW = 8;
  localparam int unsigned GroupW = 7;
  localparam int unsigned RankW  = 11;
  localparam logic OpLoad  = 1'b0;
  localparam logic OpFetch = 1'b1;
endpackage

[rtl/sgr_cmp.sv]
// Sort-key compare unit: score descending, then id ascending.
// Depends on sgr_pkg.
module sgr_cmp (
  input  logic [sgr_pkg::ScoreW-1:0] a_score_i,
  input  logic [sgr_pkg::IdW-1:0]    a_id_i,
  input  logic [sgr_pkg::ScoreW-1:0] b_score_i,
  input  logic [sgr_pkg::IdW-1:0]    b_id_i,
  output logic                       a_first_o
);
  // Order by score, break ties by the smaller id
  assign a_first_o = (a_score_i != b_score_i) ? (a_score_i > b_score_i)
                                              : (a_id_i < b_id_i);
endmodule

[rtl/sort_and_group_rank.sv]
// Top level of the sort and group rank block; depends on sgr_pkg and sgr_cmp.
// Load: accepted back to back while idle. First fetch after loading: insertion sort, with
// a key fetch per record and a read, key load and compare step for each comparison, then
// a clear of the group flags before the normal fetch path.
// Fetch: result registered after states F0, F1, F2 and OUT; input stalled until taken.
// Reset (asynchronous, active low) clears counters and flags; stores are unset.
module sort_and_group_rank #(
  parameter int unsigned MAX_RECORDS = sgr_pkg::MaxRecords,
  parameter int unsigned MAX_GROUPS  = sgr_pkg::MaxGroups
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic [sgr_pkg::IdW-1:0]    rec_id_i,
  input  logic [sgr_pkg::ScoreW-1:0] rec_score_i,
  input  logic [sgr_pkg::GroupW-1:0] rec_group_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sgr_pkg::IdW-1:0]    out_id_o,
  output logic [sgr_pkg::RankW-1:0]  overall_rank_o,
  output logic [sgr_pkg::GroupW-1:0] out_group_o,
  output logic [sgr_pkg::RankW-1:0]  group_rank_o,
  output logic [sgr_pkg::RankW-1:0]  total_count_o,
  output logic                       is_last_o,
  output logic                       overflow_o
);
  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SI, S_SR, S_SK, S_SC, S_CLR, S_F0, S_F1, S_F2, S_OUT
  } state_e;

  logic [sgr_pkg::IdW-1:0]    id_mem    [MAX_RECORDS];
  logic [sgr_pkg::ScoreW-1:0] score_mem [MAX_RECORDS];
  logic [sgr_pkg::GroupW-1:0] group_mem [MAX_RECORDS];
  logic [AW-1:0]              order_mem [MAX_RECORDS];
  logic [sgr_pkg::ScoreW-1:0] g_last_mem [MAX_GROUPS];
  logic [CW-1:0]              g_rank_mem [MAX_GROUPS];
  logic [CW-1:0]              g_tie_mem  [MAX_GROUPS];
  logic [MAX_GROUPS-1:0]      g_seen_q;

  state_e state_q;
  logic [CW-1:0] count_q, emit_q, i_q, j_q, rank_q, tie_q;
  logic [sgr_pkg::ScoreW-1:0] last_q;
  logic sorted_q, ovf_q;
  // sort working registers
  logic [sgr_pkg::IdW-1:0]    cur_id_q, cmp_id_q;
  logic [sgr_pkg::ScoreW-1:0] cur_sc_q, cmp_sc_q;
  logic [AW-1:0]              prev_q;
  logic cur_first;
  // fetch data
  logic [AW-1:0] rec_q;
  logic [sgr_pkg::IdW-1:0]    f_id_q;
  logic [sgr_pkg::ScoreW-1:0] f_sc_q;
  logic [sgr_pkg::GroupW-1:0] f_grp_q;
  logic [sgr_pkg::ScoreW-1:0] gl_q;
  logic [CW-1:0] gr_q, gt_q;
  logic [GW-1:0] gidx;
  logic [CW-1:0] nrank, ntie, ngr, ngt;

  sgr_cmp u_cmp (
    .a_score_i(cur_sc_q), .a_id_i(cur_id_q),
    .b_score_i(cmp_sc_q), .b_id_i(cmp_id_q), .a_first_o(cur_first)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign gidx = GW'(f_grp_q % MAX_GROUPS);

  // Rank updates for the record being emitted
  always_comb begin
    if (emit_q == '0) begin
      nrank = CW'(1); ntie = CW'(1);
    end else if (last_q != f_sc_q) begin
      nrank = rank_q + tie_q; ntie = CW'(1);
    end else begin
      nrank = rank_q; ntie = tie_q + CW'(1);
    end
    if (!g_seen_q[gidx]) begin
      ngr = CW'(1); ngt = CW'(1);
    end else if (gl_q != f_sc_q) begin
      ngr = gr_q + gt_q; ngt = CW'(1);
    end else begin
      ngr = gr_q; ngt = gt_q + CW'(1);
    end
  end

  // Record stores: load writes, sort and fetch reads
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && op_i == sgr_pkg::OpLoad &&
        count_q < CW'(MAX_RECORDS)) begin
      id_mem[count_q[AW-1:0]]    <= rec_id_i;
      score_mem[count_q[AW-1:0]] <= rec_score_i;
      group_mem[count_q[AW-1:0]] <= rec_group_i;
    end
    if (state_q == S_SI) begin
      cur_id_q <= id_mem[i_q[AW-1:0]];
      cur_sc_q <= score_mem[i_q[AW-1:0]];
    end
    if (state_q == S_SK) begin
      cmp_id_q <= id_mem[prev_q];
      cmp_sc_q <= score_mem[prev_q];
    end
    if (state_q == S_F1) begin
      f_id_q  <= id_mem[rec_q];
      f_sc_q  <= score_mem[rec_q];
      f_grp_q <= group_mem[rec_q];
    end
  end

  // Order memory: two read ports, one write port
  always_ff @(posedge clk_i) begin
    if (state_q == S_SR || state_q == S_F0)
      prev_q <= order_mem[(state_q == S_F0) ? emit_q[AW-1:0] : AW'(j_q - CW'(1))];
    if (state_q == S_F0) rec_q <= order_mem[emit_q[AW-1:0]];
    if (state_q == S_SC && j_q != '0 && cur_first)
      order_mem[j_q[AW-1:0]] <= prev_q;
    else if ((state_q == S_SC && (j_q == '0 || !cur_first)) || state_q == S_SI && i_q == '0)
      order_mem[j_q[AW-1:0]] <= i_q[AW-1:0];
  end

  // Per-group rank memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_F2) begin
      gl_q <= g_last_mem[gidx];
      gr_q <= g_rank_mem[gidx];
      gt_q <= g_tie_mem[gidx];
    end
    if (state_q == S_OUT && !out_valid_o) begin
      g_last_mem[gidx] <= f_sc_q;
      g_rank_mem[gidx] <= ngr;
      g_tie_mem[gidx]  <= ngt;
    end
  end

  // Sequencer: load, sort, clear, fetch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; emit_q <= '0; i_q <= '0; j_q <= '0;
      rank_q <= '0; tie_q <= '0; last_q <= '0; sorted_q <= 1'b0; ovf_q <= 1'b0;
      g_seen_q <= '0; out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (op_i == sgr_pkg::OpLoad) begin
              if (count_q < CW'(MAX_RECORDS)) count_q <= count_q + CW'(1);
              else ovf_q <= 1'b1;
              sorted_q <= 1'b0;
            end else if (!sorted_q) begin
              i_q <= '0; j_q <= '0;
              state_q <= (count_q == '0) ? S_CLR : S_SI;
            end else if (emit_q < count_q) begin
              state_q <= S_F0;
            end
          end
        end
        // fetch new key i; j starts at i
        S_SI: begin
          j_q <= i_q;
          state_q <= (i_q == '0) ? S_SC : S_SR;
        end
        // read order[j-1], then load its key
        S_SR: state_q <= S_SK;
        S_SK: state_q <= S_SC;
        // compare key i against order[j-1]; shift or place
        S_SC: begin
          if (j_q == '0 || !cur_first) begin
            if (i_q + CW'(1) >= count_q) begin
              state_q <= S_CLR;
            end else begin
              i_q <= i_q + CW'(1); state_q <= S_SI;
            end
          end else begin
            j_q <= j_q - CW'(1);
            state_q <= S_SR;
          end
        end
        S_CLR: begin
          g_seen_q <= '0;
          emit_q <= '0; rank_q <= '0; tie_q <= '0; last_q <= '0;
          sorted_q <= 1'b1;
          state_q <= (count_q == '0) ? S_IDLE : S_F0;
        end
        S_F0: state_q <= S_F1;
        S_F1: state_q <= S_F2;
        S_F2: state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_o) begin
            out_id_o <= f_id_q; out_group_o <= f_grp_q;
            overall_rank_o <= sgr_pkg::RankW'(nrank);
            group_rank_o <= sgr_pkg::RankW'(ngr);
            total_count_o <= sgr_pkg::RankW'(count_q);
            is_last_o <= (emit_q + CW'(1) == count_q);
            overflow_o <= ovf_q;
            rank_q <= nrank; tie_q <= ntie; last_q <= f_sc_q;
            g_seen_q[gidx] <= 1'b1;
            emit_q <= emit_q + CW'(1);
            out_valid_o <= 1'b1;
          end else if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/sgr_checker.sv]
// Port-level checks for sort_and_group_rank, bound to the top level.
// Depends on sort_and_group_rank.
module sgr_checker (
  input logic clk_i, rst_ni, in_valid_i, in_stall_o, out_valid_o, out_stall_i,
  input logic [10:0] overall_rank_o, group_rank_o, total_count_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(overall_rank_o))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during output");
  a_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> overall_rank_o != 0 && group_rank_o != 0 &&
    overall_rank_o <= total_count_o) else $error("rank out of range");
  a_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> group_rank_o <= overall_rank_o) else $error("group rank too big");
endmodule

bind sort_and_group_rank sgr_checker u_sgr_checker (.*);
